/* rtl/mtrg_pkg.sv */
package mtrg_pkg;

  // Store geometry
  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int ADDR_W       = 10;
  localparam int WORD_W       = 32;

  localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] WORDS_CNT  = ADDR_W'(STATE_WORDS);

  // Recurrence and tempering constants
  localparam logic [WORD_W-1:0] TW_MATRIX  = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TW_UPPER   = 32'h80000000;
  localparam logic [WORD_W-1:0] TW_LOWER   = 32'h7fffffff;
  localparam logic [WORD_W-1:0] INIT_MULT  = 32'h6c078965;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc60000;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

  typedef struct packed {
    logic              bounded;
    logic [WORD_W-1:0] range_limit;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              range_error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_FILL_SEED,
    ST_FILL_MUL,
    ST_FILL_ADD,
    ST_TW_PRE,
    ST_TW_LOAD,
    ST_TW_NXT,
    ST_TW_FAR,
    ST_TW_WR,
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_CHK
  } state_t;

  // Output tempering of one store word
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // One twist step: new value of word k
  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] y;
    mix = (cur & TW_UPPER) | (nxt & TW_LOWER);
    y   = far ^ (mix >> 1);
    if (nxt[0]) begin
      y = y ^ TW_MATRIX;
    end
    return y;
  endfunction

  // Smallest all-ones mask covering r
  function automatic logic [WORD_W-1:0] span_mask(input logic [WORD_W-1:0] r);
    logic [WORD_W-1:0] m;
    m = r;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

endpackage

/* rtl/mtrg_ram.sv */
module mtrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mt19937_random_generator.sv */
// MT19937 generator. Raise start for one cycle while busy is low; the result
// beat appears on out_item with out_valid high for exactly one cycle and is
// not held, since the receiver cannot stall. A raw draw reads the next store
// word, tempers and checks it, then registers the beat; a bounded draw repeats
// the read and check for each rejected draw (under two rejections on average).
// Every 624th draw first twists the whole store, word by word through the
// single store read port. After reset and after each cfg_we write the store is
// refilled from the seed, each word through the registered 32x32 multiply, and
// twisted, during which busy is high. A bounded request with range 0 gives
// value 0 with range_error set, in the cycle after start, without drawing.
module mt19937_random_generator (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  mtrg_pkg::in_item_t      in_item,
  output logic                    out_valid,
  output mtrg_pkg::out_item_t     out_item,
  input  logic                    cfg_we,
  input  logic [mtrg_pkg::WORD_W-1:0] cfg_data
);

  mtrg_pkg::state_t state_r, state_nxt;

  logic [mtrg_pkg::WORD_W-1:0] seed_r, seed_nxt;
  logic [mtrg_pkg::ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [mtrg_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  logic                        draw_pend_r, draw_pend_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [mtrg_pkg::WORD_W-1:0] p_r, p_nxt;
  logic [mtrg_pkg::WORD_W-1:0] prod_r, prod_nxt;
  logic [mtrg_pkg::WORD_W-1:0] cur_r, cur_nxt;
  logic [mtrg_pkg::WORD_W-1:0] nxt_r, nxt_nxt;
  logic                        bounded_r, bounded_nxt;
  logic [mtrg_pkg::WORD_W-1:0] range_r, range_nxt;
  logic [mtrg_pkg::WORD_W-1:0] mask_r, mask_nxt;
  mtrg_pkg::out_item_t         out_item_r, out_item_nxt;

  // Store port signals
  logic                        ram_we;
  logic [mtrg_pkg::ADDR_W-1:0] ram_waddr;
  logic [mtrg_pkg::WORD_W-1:0] ram_wdata;
  logic [mtrg_pkg::ADDR_W-1:0] ram_raddr;
  logic [mtrg_pkg::WORD_W-1:0] ram_rdata;

  // Datapath helpers
  logic [mtrg_pkg::WORD_W-1:0] p_mix;
  logic [mtrg_pkg::WORD_W-1:0] fill_word;
  logic [mtrg_pkg::WORD_W-1:0] tw_word;
  logic [mtrg_pkg::WORD_W-1:0] draw_val;
  logic [mtrg_pkg::ADDR_W:0]   far_sum;
  logic [mtrg_pkg::ADDR_W-1:0] far_addr;
  logic [mtrg_pkg::ADDR_W-1:0] next_addr;

  mtrg_ram #(
    .WIDTH (mtrg_pkg::WORD_W),
    .DEPTH (mtrg_pkg::STATE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Seeding recurrence and twist neighbor addresses
  assign p_mix     = p_r ^ (p_r >> 30);
  assign prod_nxt  = (state_r == mtrg_pkg::ST_FILL_MUL) ? mtrg_pkg::INIT_MULT * p_mix : prod_r;
  assign fill_word = prod_r + {{(mtrg_pkg::WORD_W-mtrg_pkg::ADDR_W){1'b0}}, cnt_r};
  assign far_sum   = {1'b0, cnt_r} + (mtrg_pkg::ADDR_W+1)'(mtrg_pkg::SHIFT_OFFSET);
  assign far_addr  = (far_sum >= (mtrg_pkg::ADDR_W+1)'(mtrg_pkg::STATE_WORDS)) ?
                     mtrg_pkg::ADDR_W'(far_sum - (mtrg_pkg::ADDR_W+1)'(mtrg_pkg::STATE_WORDS)) :
                     far_sum[mtrg_pkg::ADDR_W-1:0];
  assign next_addr = (cnt_r == mtrg_pkg::LAST_WORD) ? '0 : cnt_r + 1'b1;
  assign tw_word   = mtrg_pkg::twist_word(cur_r, nxt_r, ram_rdata);
  assign draw_val  = mtrg_pkg::temper(ram_rdata) & mask_r;

  // Sequencer: next state, store port and beat
  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    draw_pend_nxt = draw_pend_r;
    out_valid_nxt = 1'b0;
    p_nxt         = p_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    bounded_nxt   = bounded_r;
    range_nxt     = range_r;
    mask_nxt      = mask_r;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = fill_word;
    ram_raddr     = cnt_r;

    case (state_r)
      mtrg_pkg::ST_FILL_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed_r;
        p_nxt     = seed_r;
        cnt_nxt   = mtrg_pkg::ADDR_W'(1);
        state_nxt = mtrg_pkg::ST_FILL_MUL;
      end
      mtrg_pkg::ST_FILL_MUL: begin
        state_nxt = mtrg_pkg::ST_FILL_ADD;
      end
      mtrg_pkg::ST_FILL_ADD: begin
        ram_we = 1'b1;
        p_nxt  = fill_word;
        if (cnt_r == mtrg_pkg::LAST_WORD) begin
          cnt_nxt   = '0;
          state_nxt = mtrg_pkg::ST_TW_PRE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = mtrg_pkg::ST_FILL_MUL;
        end
      end
      mtrg_pkg::ST_TW_PRE: begin
        ram_raddr = '0;
        state_nxt = mtrg_pkg::ST_TW_LOAD;
      end
      mtrg_pkg::ST_TW_LOAD: begin
        cur_nxt   = ram_rdata;
        ram_raddr = next_addr;
        state_nxt = mtrg_pkg::ST_TW_FAR;
      end
      mtrg_pkg::ST_TW_NXT: begin
        ram_raddr = next_addr;
        state_nxt = mtrg_pkg::ST_TW_FAR;
      end
      mtrg_pkg::ST_TW_FAR: begin
        nxt_nxt   = ram_rdata;
        ram_raddr = far_addr;
        state_nxt = mtrg_pkg::ST_TW_WR;
      end
      mtrg_pkg::ST_TW_WR: begin
        // word k is rewritten; its old neighbor becomes the next current word
        ram_we    = 1'b1;
        ram_wdata = tw_word;
        cur_nxt   = nxt_r;
        if (cnt_r == mtrg_pkg::LAST_WORD) begin
          cnt_nxt       = '0;
          idx_nxt       = '0;
          draw_pend_nxt = 1'b0;
          state_nxt     = draw_pend_r ? mtrg_pkg::ST_DRAW_RD : mtrg_pkg::ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = mtrg_pkg::ST_TW_NXT;
        end
      end
      mtrg_pkg::ST_IDLE: begin
        if (start) begin
          bounded_nxt = in_item.bounded;
          range_nxt   = in_item.range_limit;
          mask_nxt    = in_item.bounded ? mtrg_pkg::span_mask(in_item.range_limit) : '1;
          if (in_item.bounded && (in_item.range_limit == '0)) begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.value       = '0;
            out_item_nxt.range_error = 1'b1;
          end else if (idx_r == mtrg_pkg::WORDS_CNT) begin
            draw_pend_nxt = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = mtrg_pkg::ST_TW_PRE;
          end else begin
            state_nxt = mtrg_pkg::ST_DRAW_RD;
          end
        end
      end
      mtrg_pkg::ST_DRAW_RD: begin
        ram_raddr = idx_r;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = mtrg_pkg::ST_DRAW_CHK;
      end
      mtrg_pkg::ST_DRAW_CHK: begin
        if (bounded_r && (draw_val >= range_r)) begin
          // rejected: draw again, twisting first if the store is spent
          if (idx_r == mtrg_pkg::WORDS_CNT) begin
            draw_pend_nxt = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = mtrg_pkg::ST_TW_PRE;
          end else begin
            state_nxt = mtrg_pkg::ST_DRAW_RD;
          end
        end else begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.value       = draw_val;
          out_item_nxt.range_error = 1'b0;
          state_nxt                = mtrg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mtrg_pkg::ST_IDLE;
      end
    endcase

    // a seed write restarts seeding
    if (cfg_we) begin
      seed_nxt      = cfg_data;
      draw_pend_nxt = 1'b0;
      out_valid_nxt = 1'b0;
      state_nxt     = mtrg_pkg::ST_FILL_SEED;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtrg_pkg::ST_FILL_SEED;
      seed_r      <= mtrg_pkg::SEED_RESET;
      cnt_r       <= '0;
      idx_r       <= '0;
      draw_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      draw_pend_r <= draw_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    prod_r     <= prod_nxt;
    cur_r      <= cur_nxt;
    nxt_r      <= nxt_nxt;
    bounded_r  <= bounded_nxt;
    range_r    <= range_nxt;
    mask_r     <= mask_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != mtrg_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.range_error |-> out_item.value == '0)
    else $error("range_error beat with nonzero value");

  a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cfg_we && in_item.bounded && in_item.range_limit == '0
    |=> out_valid && out_item.range_error)
    else $error("zero range did not flag an error");

  a_bounded_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bounded_r && !out_item.range_error |-> out_item.value < range_r)
    else $error("bounded beat not below range");

  a_idx_limit: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= mtrg_pkg::WORDS_CNT)
    else $error("word index past store end");

  a_cfg_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> state_r == mtrg_pkg::ST_FILL_SEED && seed_r == $past(cfg_data))
    else $error("seed write did not restart seeding");

endmodule
